@@ rtl/rtbl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table package
// Shared types, operation and status codes for the IPv6 route table.
// ----------------------------------------------------------------------------
package rtbl_pkg;

  // Operation codes.
  localparam logic [2:0] OP_LOOKUP    = 3'd0;
  localparam logic [2:0] OP_ADD       = 3'd1;
  localparam logic [2:0] OP_REM_INDEX = 3'd2;
  localparam logic [2:0] OP_REM_MATCH = 3'd3;
  localparam logic [2:0] OP_IF_DOWN   = 3'd4;
  localparam logic [2:0] OP_READ      = 3'd5;

  // Status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_ROUTE = 3'd1;
  localparam logic [2:0] ST_DUP      = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_BAD_IDX  = 3'd4;
  localparam logic [2:0] ST_NO_IFACE = 3'd5;

  localparam logic [7:0]  FULL_PREFIX   = 8'd128;
  localparam logic [31:0] WORST_METRIC  = 32'hffff_ffff;
  localparam logic [15:0] LL_MCAST      = 16'hff02;
  localparam int          DEF_TABLE_DEPTH = 64;

  // One stored route.
  typedef struct packed {
    logic [63:0] net_hi;
    logic [63:0] net_lo;
    logic [7:0]  plen;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [7:0]  iface;
    logic [31:0] metric;
  } entry_t;

  // Contents of one cell: a route and a mark for a slot that holds no route.
  typedef struct packed {
    entry_t e;
    logic   hole;
  } slot_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;
    logic pair_lo;
    logic pair_hi;
    logic wr;
  } cell_ctl_t;

  // Latched command.
  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [7:0]  plen;
    logic [63:0] gw_hi;
    logic [63:0] gw_lo;
    logic [7:0]  iface;
    logic        given;
    logic [31:0] metric;
    logic [5:0]  idx;
  } cmd_t;

  // Running state of a lookup.
  typedef struct packed {
    logic [7:0]  longest;
    logic [31:0] shortest;
    logic        stopped;
  } lk_t;

  // Decisions made on the entry at the head of the chain.
  typedef struct packed {
    logic  upd;
    lk_t   lk_next;
    logic  take;
    logic  dup_hit;
    logic  drop;
    logic  read_hit;
  } head_res_t;

endpackage

@@ rtl/ipv6_longest_prefix_route_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 longest prefix route table
// Ordered route table in a chain of cells with lookup, add, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the command fields and raise start while busy is low; the command
//   transfer happens at that clock edge and busy rises on the next cycle.
//   The routes sit in a chain of TABLE_DEPTH cells. Every command rotates the
//   whole chain once past a single head evaluator, one route per cycle.
//   Remove index, remove match and interface down then close the gaps with
//   an odd-even swap pass. The result is then formed in the done state.
//   A new command is taken only after the previous one has finished, and
//   the next command can transfer while done is high.
//   The result is on the result ports for one cycle with done high, and its
//   transfer is at the end of that cycle; the receiver cannot stall it.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ipv6_longest_prefix_route_table_core #(
  parameter int TABLE_DEPTH = rtbl_pkg::DEF_TABLE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [7:0]  prefix_len,
  input  logic [63:0] gateway_hi,
  input  logic [63:0] gateway_lo,
  input  logic [7:0]  iface,
  input  logic        iface_given,
  input  logic [31:0] route_metric,
  input  logic [5:0]  entry_index,
  output logic        done,
  output logic [2:0]  status,
  output logic [5:0]  hit_index,
  output logic [7:0]  out_iface,
  output logic [63:0] next_hop_hi,
  output logic [63:0] next_hop_lo,
  output logic [31:0] hit_metric,
  output logic [6:0]  removed_count,
  output logic [6:0]  table_count
);
  import rtbl_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_SORT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state;
  logic [IW-1:0] step;
  logic [CW-1:0] total;
  logic [CW-1:0] gone;
  cmd_t          cmd;
  lk_t           lk;
  logic          found;
  logic          dup_found;
  logic [5:0]    sel_idx;
  entry_t        sel_e;

  slot_t         slots [TABLE_DEPTH];
  cell_ctl_t     ctls  [TABLE_DEPTH];
  slot_t         head_fb;
  head_res_t     hres;
  logic          in_range;
  logic          at_idx;
  logic          last_step;
  logic          idx_ok;
  logic          add_ok;
  logic          is_removal;
  entry_t        new_e;

  assign busy      = (state != S_IDLE);
  assign last_step = (step == IW'(TABLE_DEPTH - 1));
  assign in_range  = (CW'(step) < total);
  assign at_idx    = (XW'(step) == XW'(cmd.idx));
  assign idx_ok    = (XW'(cmd.idx) < XW'(total));
  assign add_ok    = (cmd.op == OP_ADD) && !dup_found && (total < CW'(TABLE_DEPTH));
  assign is_removal = (cmd.op == OP_REM_INDEX) || (cmd.op == OP_REM_MATCH) ||
                      (cmd.op == OP_IF_DOWN);

  // Route built from the command for an add.
  assign new_e = '{net_hi: cmd.addr_hi, net_lo: cmd.addr_lo, plen: cmd.plen,
                   gw_hi: cmd.gw_hi, gw_lo: cmd.gw_lo, iface: cmd.iface,
                   metric: cmd.metric};

  rtbl_head u_head (
    .cmd       (cmd),
    .e         (slots[0].e),
    .in_range  (in_range),
    .at_idx    (at_idx),
    .lk        (lk),
    .dup_found (dup_found),
    .res       (hres)
  );

  // The head route returns to the tail, marked as a hole if dropped or unused.
  assign head_fb = '{e: slots[0].e, hole: !in_range || hres.drop};

  // Chain of cells.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    slot_t rin;
    slot_t lin;
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign rin = head_fb;
    end else begin : g_mid
      assign rin = slots[i+1];
    end
    if (i == 0) begin : g_first
      assign lin = '0;
    end else begin : g_rest
      assign lin = slots[i-1];
    end
    assign ctls[i].shift   = (state == S_SCAN);
    assign ctls[i].pair_lo = (state == S_SORT) && (i + 1 < TABLE_DEPTH) &&
                             (step[0] == 1'(i % 2));
    assign ctls[i].pair_hi = (state == S_SORT) && (i >= 1) &&
                             (step[0] == 1'((i + 1) % 2));
    assign ctls[i].wr      = (state == S_DONE) && add_ok && (total == CW'(i));
    rtbl_cell u_cell (
      .clk  (clk),
      .ctl  (ctls[i]),
      .wr_e (new_e),
      .rin  (rin),
      .lin  (lin),
      .q    (slots[i])
    );
  end

  // Sequencer: scan, optional compaction, then result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      total <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            step  <= '0;
          end
        end
        S_SCAN: begin
          step <= step + 1'b1;
          if (last_step) begin
            step  <= '0;
            state <= is_removal ? S_SORT : S_DONE;
          end
        end
        S_SORT: begin
          step <= step + 1'b1;
          if (last_step) state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
          done  <= 1'b1;
          if (add_ok) total <= total + 1'b1;
          else if (is_removal) total <= total - gone;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Command latch and scan results.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd.op      <= op;
      cmd.addr_hi <= addr_hi;
      cmd.addr_lo <= addr_lo;
      cmd.plen    <= (prefix_len > FULL_PREFIX) ? FULL_PREFIX : prefix_len;
      cmd.gw_hi   <= gateway_hi;
      cmd.gw_lo   <= gateway_lo;
      cmd.iface   <= iface;
      cmd.given   <= iface_given;
      cmd.metric  <= route_metric;
      cmd.idx     <= entry_index;
      lk          <= '{longest: 8'd0, shortest: WORST_METRIC, stopped: 1'b0};
      found       <= 1'b0;
      dup_found   <= 1'b0;
      gone        <= '0;
    end else if (state == S_SCAN) begin
      if (hres.upd) lk <= hres.lk_next;
      if (hres.take || hres.dup_hit || hres.read_hit) begin
        sel_idx <= 6'(step);
        sel_e   <= slots[0].e;
      end
      if (hres.take) found <= 1'b1;
      if (hres.dup_hit) dup_found <= 1'b1;
      if (hres.drop) gone <= gone + 1'b1;
    end
  end

  // Result formation.
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      status        <= ST_OK;
      hit_index     <= '0;
      out_iface     <= '0;
      next_hop_hi   <= '0;
      next_hop_lo   <= '0;
      hit_metric    <= '0;
      removed_count <= '0;
      table_count   <= 7'(total);
      case (cmd.op)
        OP_LOOKUP: begin
          if (cmd.addr_hi[63:48] == LL_MCAST) begin
            if (cmd.given) out_iface <= cmd.iface;
            else status <= ST_NO_IFACE;
          end else if (found) begin
            hit_index   <= sel_idx;
            out_iface   <= sel_e.iface;
            next_hop_hi <= sel_e.gw_hi;
            next_hop_lo <= sel_e.gw_lo;
            hit_metric  <= sel_e.metric;
          end else begin
            status <= ST_NO_ROUTE;
          end
        end
        OP_ADD: begin
          if (dup_found) begin
            status    <= ST_DUP;
            hit_index <= sel_idx;
          end else if (!add_ok) begin
            status <= ST_FULL;
          end else begin
            hit_index   <= 6'(total);
            table_count <= 7'(total + 1'b1);
          end
        end
        OP_REM_INDEX, OP_REM_MATCH, OP_IF_DOWN: begin
          removed_count <= 7'(gone);
          table_count   <= 7'(total - gone);
          if (cmd.op == OP_REM_INDEX) begin
            if (idx_ok) hit_index <= cmd.idx;
            else status <= ST_BAD_IDX;
          end else if (cmd.op == OP_REM_MATCH && gone == '0) begin
            status <= ST_NO_ROUTE;
          end
        end
        OP_READ: begin
          if (idx_ok) begin
            hit_index   <= cmd.idx;
            out_iface   <= sel_e.iface;
            next_hop_hi <= sel_e.gw_hi;
            next_hop_lo <= sel_e.gw_lo;
            hit_metric  <= sel_e.metric;
          end else begin
            status <= ST_BAD_IDX;
          end
        end
        default: status <= ST_OK;
      endcase
    end
  end

`ifndef SYNTHESIS
  // The route count never exceeds the table depth.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= CW'(TABLE_DEPTH))
    else $error("route count beyond table depth");

  // A result strobe is a single cycle and only follows the final state.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE) && $past(state) == S_DONE)
    else $error("result strobe outside result cycle");

  // A command transfer always starts a scan.
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_SCAN) && (step == '0))
    else $error("command transfer did not start a scan");

  // A full status only comes from a full table.
  a_full_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (total == CW'(TABLE_DEPTH)))
    else $error("full status with room left");

  // Compaction never removes more routes than were present.
  a_gone_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && is_removal) |-> (gone <= total))
    else $error("removed count beyond route count");
`endif

endmodule

@@ rtl/rtbl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table cell
// Holds one table slot; rotates, swaps holes toward the tail, or is written.
// ----------------------------------------------------------------------------
module rtbl_cell (
  input  logic               clk,
  input  rtbl_pkg::cell_ctl_t ctl,
  input  rtbl_pkg::entry_t   wr_e,
  input  rtbl_pkg::slot_t    rin,
  input  rtbl_pkg::slot_t    lin,
  output rtbl_pkg::slot_t    q
);
  import rtbl_pkg::*;

  slot_t data;

  // Rotation takes the right neighbor; a pair swap moves a hole one place up.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      data <= '{e: wr_e, hole: 1'b0};
    end else if (ctl.shift) begin
      data <= rin;
    end else if (ctl.pair_lo && data.hole && !rin.hole) begin
      data <= rin;
    end else if (ctl.pair_hi && lin.hole && !data.hole) begin
      data <= lin;
    end
  end

  assign q = data;

endmodule

@@ rtl/rtbl_head.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table head evaluator
// Judges the route at the head of the chain against the current command.
// ----------------------------------------------------------------------------
module rtbl_head (
  input  rtbl_pkg::cmd_t      cmd,
  input  rtbl_pkg::entry_t    e,
  input  logic                in_range,
  input  logic                at_idx,
  input  rtbl_pkg::lk_t       lk,
  input  logic                dup_found,
  output rtbl_pkg::head_res_t res
);
  import rtbl_pkg::*;

  logic [63:0] mask_hi;
  logic [63:0] mask_lo;
  logic [6:0]  lo_sh;
  logic        pmatch;
  logic        if_eq;
  logic        net_eq;
  logic        cand;
  logic [31:0] short_base;

  // Network masks from the stored prefix length.
  always_comb begin
    lo_sh = 7'(e.plen) - 7'd64;
    if (e.plen >= 8'd64) mask_hi = '1;
    else mask_hi = ~({64{1'b1}} >> e.plen);
    if (e.plen <= 8'd64) mask_lo = '0;
    else if (e.plen >= FULL_PREFIX) mask_lo = '1;
    else mask_lo = ~({64{1'b1}} >> lo_sh);
  end

  assign pmatch = (((cmd.addr_hi ^ e.net_hi) & mask_hi) == 64'd0) &&
                  (((cmd.addr_lo ^ e.net_lo) & mask_lo) == 64'd0);
  assign if_eq  = (e.iface == cmd.iface);
  assign net_eq = (e.net_hi == cmd.addr_hi) && (e.net_lo == cmd.addr_lo) &&
                  (e.plen == cmd.plen);

  // Longest prefix, then lowest metric, later entry winning a tie.
  assign cand = (cmd.op == OP_LOOKUP) && in_range && !lk.stopped && pmatch &&
                (!cmd.given || if_eq) && (e.plen >= lk.longest);
  assign short_base = (e.plen > lk.longest) ? WORST_METRIC : lk.shortest;

  always_comb begin
    res.upd              = cand;
    res.lk_next.longest  = e.plen;
    res.lk_next.shortest = short_base;
    res.lk_next.stopped  = lk.stopped;
    res.take             = 1'b0;
    if (cand && (e.metric <= short_base)) begin
      res.take             = 1'b1;
      res.lk_next.shortest = e.metric;
      res.lk_next.stopped  = (e.plen == FULL_PREFIX);
    end
    res.dup_hit = (cmd.op == OP_ADD) && in_range && !dup_found && net_eq &&
                  (e.gw_hi == cmd.gw_hi) && (e.gw_lo == cmd.gw_lo) && if_eq &&
                  (e.metric == cmd.metric);
    res.read_hit = (cmd.op == OP_READ) && in_range && at_idx;
    case (cmd.op)
      OP_REM_INDEX: res.drop = in_range && at_idx;
      OP_REM_MATCH: res.drop = in_range && net_eq && if_eq;
      OP_IF_DOWN:   res.drop = in_range && if_eq;
      default:      res.drop = 1'b0;
    endcase
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv6 route table core testbench
// Drives route table commands through the start/busy handshake and mirrors
// the table contents in a behavioral copy. Every done strobe is checked field
// by field against the oldest predicted result. A short table of directed
// commands comes first, then random traffic in several sender idling phases.
// ----------------------------------------------------------------------------
module tb_top;
  import rtbl_pkg::*;

  localparam int DEPTH       = 64;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 480;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  hit;
    logic [7:0]  oif;
    logic [63:0] nh_hi;
    logic [63:0] nh_lo;
    logic [31:0] metric;
    logic [6:0]  removed;
    logic [6:0]  count;
  } route_res_t;

  // A directed row: the command and, where known up front, its result.
  typedef struct packed {
    cmd_t       c;
    logic       typed;
    route_res_t r;
  } dir_row_t;

  logic clk, rst, start, busy, done;
  cmd_t drv;
  logic [2:0]  status;
  logic [5:0]  hit_index;
  logic [7:0]  out_iface;
  logic [63:0] next_hop_hi, next_hop_lo;
  logic [31:0] hit_metric;
  logic [6:0]  removed_count, table_count;

  // Mirror of the route table.
  entry_t route_tab [DEPTH];
  int     route_cnt;

  route_res_t pending_results[$];
  dir_row_t   dir_rows[$];
  logic [127:0] net_pool [6];

  int fails, checked, items_sent, full_seen, dup_seen, lookup_hits;

  ipv6_longest_prefix_route_table_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(drv.op), .addr_hi(drv.addr_hi), .addr_lo(drv.addr_lo),
    .prefix_len(drv.plen), .gateway_hi(drv.gw_hi), .gateway_lo(drv.gw_lo),
    .iface(drv.iface), .iface_given(drv.given), .route_metric(drv.metric),
    .entry_index(drv.idx), .done(done), .status(status),
    .hit_index(hit_index), .out_iface(out_iface), .next_hop_hi(next_hop_hi),
    .next_hop_lo(next_hop_lo), .hit_metric(hit_metric),
    .removed_count(removed_count), .table_count(table_count)
  );

  // Clock generation.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prefix comparison with both sides masked.
  function automatic bit prefix_hit(logic [127:0] a, logic [127:0] n, int p);
    logic [127:0] mask;
    mask = (p == 0) ? '0 : ({128{1'b1}} << (128 - p));
    return ((a ^ n) & mask) == '0;
  endfunction

  // Apply one command to the mirror and return the result it must produce.
  function automatic route_res_t route_table_step(cmd_t c);
    route_res_t r;
    logic [7:0] p;
    logic [127:0] a, n;
    logic [7:0] longest;
    logic [31:0] shortest;
    int pick, w, gone;
    bit found, drop;
    r = '0;
    p = (c.plen > FULL_PREFIX) ? FULL_PREFIX : c.plen;
    a = {c.addr_hi, c.addr_lo};
    case (c.op)
      OP_LOOKUP: begin
        if (c.addr_hi[63:48] == LL_MCAST) begin
          if (c.given) r.oif = c.iface;
          else r.status = ST_NO_IFACE;
        end else begin
          longest = 8'd0; shortest = WORST_METRIC; pick = 0; found = 1'b0;
          for (int i = 0; i < route_cnt; i++) begin
            n = {route_tab[i].net_hi, route_tab[i].net_lo};
            if (!prefix_hit(a, n, int'(route_tab[i].plen))) continue;
            if (c.given && route_tab[i].iface != c.iface) continue;
            if (route_tab[i].plen < longest) continue;
            if (route_tab[i].plen > longest) shortest = WORST_METRIC;
            longest = route_tab[i].plen;
            if (route_tab[i].metric > shortest) continue;
            shortest = route_tab[i].metric;
            pick = i;
            found = 1'b1;
            if (route_tab[i].plen == FULL_PREFIX) break;
          end
          if (found) begin
            r.hit = 6'(pick); r.oif = route_tab[pick].iface;
            r.nh_hi = route_tab[pick].gw_hi; r.nh_lo = route_tab[pick].gw_lo;
            r.metric = route_tab[pick].metric;
          end else r.status = ST_NO_ROUTE;
        end
      end
      OP_ADD: begin
        found = 1'b0;
        for (int i = 0; i < route_cnt; i++) begin
          if (route_tab[i] == {c.addr_hi, c.addr_lo, p, c.gw_hi, c.gw_lo, c.iface,
                               c.metric}) begin
            found = 1'b1; r.hit = 6'(i); break;
          end
        end
        if (found) r.status = ST_DUP;
        else if (route_cnt >= DEPTH) r.status = ST_FULL;
        else begin
          route_tab[route_cnt] = {c.addr_hi, c.addr_lo, p, c.gw_hi, c.gw_lo, c.iface,
                                  c.metric};
          r.hit = 6'(route_cnt);
          route_cnt++;
        end
      end
      OP_REM_INDEX, OP_REM_MATCH, OP_IF_DOWN: begin
        if (c.op == OP_REM_INDEX && c.idx >= route_cnt) r.status = ST_BAD_IDX;
        else begin
          // Drop the selected routes and close the gaps in order.
          w = 0; gone = 0;
          for (int i = 0; i < route_cnt; i++) begin
            if (c.op == OP_REM_INDEX) drop = (i == c.idx);
            else if (c.op == OP_REM_MATCH)
              drop = route_tab[i].net_hi == c.addr_hi && route_tab[i].net_lo == c.addr_lo
                     && route_tab[i].plen == p && route_tab[i].iface == c.iface;
            else drop = (route_tab[i].iface == c.iface);
            if (drop) begin
              gone++;
              continue;
            end
            route_tab[w] = route_tab[i];
            w++;
          end
          route_cnt = w;
          r.removed = 7'(gone);
          if (c.op == OP_REM_INDEX) r.hit = c.idx;
          if (c.op == OP_REM_MATCH && gone == 0) r.status = ST_NO_ROUTE;
        end
      end
      OP_READ: begin
        if (c.idx >= route_cnt) r.status = ST_BAD_IDX;
        else begin
          r.hit = c.idx; r.oif = route_tab[c.idx].iface;
          r.nh_hi = route_tab[c.idx].gw_hi; r.nh_lo = route_tab[c.idx].gw_lo;
          r.metric = route_tab[c.idx].metric;
        end
      end
      default: ;
    endcase
    r.count = 7'(route_cnt);
    return r;
  endfunction

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random command, mostly aimed at networks and routes already in play.
  function automatic cmd_t rand_cmd(int add_pct);
    cmd_t c;
    int roll, k;
    logic [127:0] a;
    logic [7:0] plens [11];
    plens = '{0, 8, 16, 32, 48, 64, 96, 112, 127, 128, 200};
    c = '0;
    roll = $urandom_range(0, 99);
    a = net_pool[$urandom_range(0, 5)];
    c.plen = ($urandom_range(0, 4) == 0) ? 8'($urandom) : plens[$urandom_range(0, 10)];
    c.iface = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    c.given = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: c.metric = 0;
      1: c.metric = WORST_METRIC;
      2: c.metric = $urandom_range(0, 7);
      default: c.metric = $urandom;
    endcase
    {c.gw_hi, c.gw_lo} = ($urandom_range(0, 3) == 0) ? '0 : rand128();
    c.idx = ($urandom_range(0, 3) == 0 || route_cnt == 0) ? 6'($urandom)
          : 6'($urandom_range(0, route_cnt - 1));
    if (roll < add_pct) begin
      c.op = OP_ADD;
      if ($urandom_range(0, 2) == 0) a = a ^ (rand128() >> $urandom_range(0, 128));
      {c.addr_hi, c.addr_lo} = a;
      if (route_cnt > 0 && $urandom_range(0, 9) == 0) begin
        k = $urandom_range(0, route_cnt - 1);
        {c.addr_hi, c.addr_lo, c.plen, c.gw_hi, c.gw_lo, c.iface, c.metric} = route_tab[k];
      end
    end else if (roll < add_pct + 30) begin
      c.op = OP_LOOKUP;
      a = a ^ (rand128() >> $urandom_range(0, 128));
      if ($urandom_range(0, 9) == 0) a = rand128();
      if ($urandom_range(0, 14) == 0) a[127:112] = LL_MCAST;
      {c.addr_hi, c.addr_lo} = a;
    end else begin
      {c.addr_hi, c.addr_lo} = a;
      case ($urandom_range(0, 9))
        0, 1: c.op = OP_REM_INDEX;
        2, 3: c.op = OP_REM_MATCH;
        4:    c.op = OP_IF_DOWN;
        5:    c.op = 3'($urandom_range(6, 7));
        default: c.op = OP_READ;
      endcase
      if (c.op == OP_REM_MATCH && route_cnt > 0 && $urandom_range(0, 2) != 0) begin
        k = $urandom_range(0, route_cnt - 1);
        c.addr_hi = route_tab[k].net_hi; c.addr_lo = route_tab[k].net_lo;
        c.plen = route_tab[k].plen; c.iface = route_tab[k].iface;
      end
    end
    return c;
  endfunction

  // Present one command and hold it until the transfer; queue its result.
  task automatic send_cmd(cmd_t c, bit typed, route_res_t typed_res);
    route_res_t r;
    route_res_t exp_r;
    drv   <= c;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    r = route_table_step(c);
    if (r.status == ST_FULL) full_seen++;
    if (r.status == ST_DUP) dup_seen++;
    if (c.op == OP_LOOKUP && r.status == ST_OK) lookup_hits++;
    exp_r = typed ? typed_res : r;
    pending_results = {pending_results, exp_r};
    items_sent++;
  endtask

  // Optional sender gap after a transfer.
  task automatic sender_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $display("%0t ns mismatch %s: expected %h actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Check each result transfer against the oldest prediction.
  always @(posedge clk) begin
    route_res_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        fails++;
        $display("%0t ns unexpected result: expected none actual status %0d",
                 $time, status);
      end else begin
        e = pending_results.pop_front();
        checked++;
        check_field("status", 64'(e.status), 64'(status));
        check_field("hit_index", 64'(e.hit), 64'(hit_index));
        check_field("out_iface", 64'(e.oif), 64'(out_iface));
        check_field("next_hop_hi", e.nh_hi, next_hop_hi);
        check_field("next_hop_lo", e.nh_lo, next_hop_lo);
        check_field("hit_metric", 64'(e.metric), 64'(hit_metric));
        check_field("removed_count", 64'(e.removed), 64'(removed_count));
        check_field("table_count", 64'(e.count), 64'(table_count));
      end
    end
  end

  // Watchdog on cycles with no transfer in either direction.
  int quiet_cycles;
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [2:0] op, logic [127:0] a, logic [7:0] p,
                              logic [127:0] g, logic [7:0] ifc, logic given,
                              logic [31:0] met, logic [5:0] idx);
    return {op, a, p, g, ifc, given, met, idx};
  endfunction

  function automatic void add_row(cmd_t c, bit typed, route_res_t r);
    dir_row_t row;
    row = '{c: c, typed: typed, r: r};
    dir_rows = {dir_rows, row};
  endfunction

  // Directed rows: error codes and extremes typed in, the rest predicted.
  task automatic build_dir_rows();
    logic [127:0] doc, ones;
    route_res_t r, none;
    doc = {64'h2001_0db8_0000_0000, 64'h0};
    ones = {128{1'b1}};
    none = '0;
    r = '0; r.status = ST_NO_ROUTE;
    add_row(mk(OP_LOOKUP, doc, 0, 0, 0, 0, 0, 0), 1, r);
    r = '0; r.status = ST_BAD_IDX;
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0), 1, r);
    add_row(mk(OP_REM_INDEX, 0, 0, 0, 0, 0, 0, 0), 1, r);
    r = '0; r.status = ST_NO_IFACE;
    add_row(mk(OP_LOOKUP, {16'hff02, 112'h1}, 0, 0, 7, 0, 0, 0), 1, r);
    r = '0; r.oif = 8'd255;
    add_row(mk(OP_LOOKUP, {16'hff02, 112'h1}, 0, 0, 255, 1, 0, 0), 1, r);
    add_row(mk(3'd6, ones, 255, ones, 255, 1, WORST_METRIC, 63), 1, none);
    add_row(mk(3'd7, ones, 255, ones, 255, 1, WORST_METRIC, 63), 1, none);
    add_row(mk(OP_ADD, 0, 0, 0, 1, 0, 10, 0), 0, none);
    add_row(mk(OP_ADD, doc, 32, ones, 1, 0, WORST_METRIC, 0), 0, none);
    add_row(mk(OP_ADD, ones, 255, ones, 255, 0, 0, 0), 0, none);
    add_row(mk(OP_ADD, doc, 32, ones, 1, 0, WORST_METRIC, 0), 0, none);
    add_row(mk(OP_ADD, doc, 32, 128'h5, 2, 0, 5, 0), 0, none);
    add_row(mk(OP_LOOKUP, doc | 128'h1, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_LOOKUP, doc | 128'h1, 0, 0, 1, 1, 0, 0), 0, none);
    add_row(mk(OP_LOOKUP, ones, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_ADD, doc, 32, 128'h9, 2, 0, 5, 0), 0, none);
    add_row(mk(OP_LOOKUP, doc | 128'h5, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 1), 0, none);
    add_row(mk(OP_READ, 0, 0, 0, 0, 0, 0, 63), 0, none);
    add_row(mk(OP_REM_MATCH, doc, 32, 0, 2, 0, 0, 0), 0, none);
    add_row(mk(OP_REM_MATCH, doc, 33, 0, 2, 0, 0, 0), 0, none);
    add_row(mk(OP_IF_DOWN, 0, 0, 0, 9, 0, 0, 0), 0, none);
    add_row(mk(OP_REM_INDEX, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(OP_IF_DOWN, 0, 0, 0, 255, 0, 0, 0), 0, none);
    add_row(mk(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0), 0, none);
  endtask

  // Main sequence.
  initial begin
    int idle_pct [4];
    int add_pct  [4];
    int tail;
    idle_pct = '{0, 70, 0, 33};
    add_pct  = '{60, 35, 30, 40};
    rst = 1'b1; start = 1'b0; drv = '0;
    route_cnt = 0; fails = 0; checked = 0; items_sent = 0;
    full_seen = 0; dup_seen = 0; lookup_hits = 0;
    net_pool[0] = '0;
    net_pool[1] = {128{1'b1}};
    net_pool[2] = {64'h2001_0db8_0000_0000, 64'h0};
    for (int i = 3; i < 6; i++) net_pool[i] = rand128();
    build_dir_rows();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
      sender_gap(50);
    end

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_cmd(rand_cmd(add_pct[ph]), 0, '0);
        sender_gap(idle_pct[ph]);
      end
      // Let the pipeline drain completely once per phase boundary.
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    tail = 2 * DEPTH + 4;
    repeat (tail) @(posedge clk);
    $display("%0d commands sent, %0d results checked, %0d mismatches", items_sent,
             checked, fails);
    $display("lookup hits %0d, duplicate adds %0d, adds to a full table %0d",
             lookup_hits, dup_seen, full_seen);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rtbl_pkg.sv
rtl/rtbl_cell.sv
rtl/rtbl_head.sv
rtl/ipv6_longest_prefix_route_table_core.sv
dv/tb_top.sv
